// ===== hw/rtl/ae_pkg.sv =====
// Shared types for the arithmetic encoder: controller states, commands and status.
`default_nettype none

package ae_pkg;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_NARROW,
		ST_RENORM,
		ST_FINISH
	} ae_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the input transaction
		logic div_start;  // form both products and seed the dividers
		logic div_step;   // one quotient bit in each divider
		logic narrow;     // write the narrowed interval
		logic rn_step;    // one renormalizing step
		logic flush;      // push the held result as the final one
		logic finish;     // emit the flush bit and reinitialize
	} ae_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic command;    // captured transaction is a finish
		logic invalid;    // captured counts are not usable
		logic div_last;   // the current divider step is the last
		logic empty;      // narrowed interval would be empty
		logic rn_done;    // interval needs no further renormalizing
		logic rn_emit;    // the next renormalizing step emits a bit
		logic hold_valid; // a result waits in the hold register
		logic out_free;   // the output register can take a result this cycle
	} ae_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ae_div.sv =====
// Restoring divider that produces one quotient bit per cycle while step is high.
`default_nettype none

module ae_div #(
	parameter int QW = 17,
	parameter int DW = 14
) (
	input  wire logic              clk,
	input  wire logic              start,
	input  wire logic              step,
	input  wire logic [DW+QW-1:0]  dividend,
	input  wire logic [DW-1:0]     divisor,
	output logic      [QW-1:0]     quotient
);

	logic [DW-1:0] rem_q;
	logic [QW-1:0] acc_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	// Bring down the next dividend bit and try the subtraction.
	always_comb begin
		trial = {rem_q, acc_q[QW-1]};
		diff  = trial - {1'b0, divisor};
		fits  = trial >= {1'b0, divisor};
	end

	// The upper dividend bits are already below the divisor, so only QW steps remain.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DW+QW-1:QW];
			acc_q <= dividend[QW-1:0];
		end else if (step) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			acc_q <= {acc_q[QW-2:0], fits};
		end
	end

	assign quotient = acc_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ae_dp.sv =====
// Datapath of the arithmetic encoder: interval, follow counter, dividers and result registers.
`default_nettype none

module ae_dp import ae_pkg::*; #(
	parameter int CODE_BITS   = 16,
	parameter int FREQ_BITS   = 14,
	parameter int FOLLOW_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ae_cmd_t                cmd,
	output ae_sts_t                     sts,
	input  wire logic                   command,
	input  wire logic [FREQ_BITS-1:0]   cum_upper,
	input  wire logic [FREQ_BITS-1:0]   cum_lower,
	input  wire logic [FREQ_BITS-1:0]   total,
	output logic                        code_valid,
	input  wire logic                   code_stall,
	output logic                        lead_bit,
	output logic [FOLLOW_BITS-1:0]      follow_count,
	output logic                        follow_saturated,
	output logic                        last
);

	localparam int RW    = CODE_BITS + 1;
	localparam int PW    = RW + FREQ_BITS;
	localparam int CNT_W = $clog2(CODE_BITS + 1);
	localparam logic [CODE_BITS-1:0] CODE_HALF = {1'b1, {(CODE_BITS-1){1'b0}}};
	localparam logic [CODE_BITS-1:0] CODE_QTR  = {2'b01, {(CODE_BITS-2){1'b0}}};
	localparam logic [CODE_BITS-1:0] CODE_3QTR = {2'b11, {(CODE_BITS-2){1'b0}}};

	// Captured transaction.
	logic                 cmd_q;
	logic [FREQ_BITS-1:0] up_q;
	logic [FREQ_BITS-1:0] lo_q;
	logic [FREQ_BITS-1:0] tot_q;

	// Encoder state.
	logic [CODE_BITS-1:0]   low_q;
	logic [CODE_BITS-1:0]   high_q;
	logic [FOLLOW_BITS-1:0] pend_q;
	logic                   povf_q;

	// Held result and output register.
	logic                   hold_valid_q;
	logic                   hold_bit_q;
	logic [FOLLOW_BITS-1:0] hold_follow_q;
	logic                   hold_sat_q;
	logic                   out_valid_q;
	logic                   out_bit_q;
	logic [FOLLOW_BITS-1:0] out_follow_q;
	logic                   out_sat_q;
	logic                   out_last_q;

	logic [CNT_W-1:0]       cnt_q;

	logic [RW-1:0]          range;
	logic [PW-1:0]          prod_a;
	logic [PW-1:0]          prod_b;
	logic [RW-1:0]          quo_a;
	logic [RW-1:0]          quo_b;
	logic [RW-1:0]          nh_wide;
	logic [CODE_BITS-1:0]   nl;
	logic                   rn_lo;
	logic                   rn_hi;
	logic                   rn_mid;
	logic                   rn_emit;
	logic [CODE_BITS-1:0]   rn_sub;
	logic [CODE_BITS-1:0]   low_sub;
	logic [CODE_BITS-1:0]   high_sub;
	logic                   pend_full;
	logic [FOLLOW_BITS-1:0] pend_inc;
	logic                   out_free;
	logic                   push;

	// Capture the transaction.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			up_q  <= cum_upper;
			lo_q  <= cum_lower;
			tot_q <= total;
		end
	end

	// Interval width and the two products of the scaling.
	always_comb begin
		range  = {1'b0, high_q} - {1'b0, low_q} + RW'(1);
		prod_a = PW'(range) * PW'(up_q);
		prod_b = PW'(range) * PW'(lo_q);
	end

	ae_div #(.QW(RW), .DW(FREQ_BITS)) u_div_a (
		.clk      (clk),
		.start    (cmd.div_start),
		.step     (cmd.div_step),
		.dividend (prod_a),
		.divisor  (tot_q),
		.quotient (quo_a)
	);

	ae_div #(.QW(RW), .DW(FREQ_BITS)) u_div_b (
		.clk      (clk),
		.start    (cmd.div_start),
		.step     (cmd.div_step),
		.dividend (prod_b),
		.divisor  (tot_q),
		.quotient (quo_b)
	);

	// Divider step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Narrowed interval edges and renormalizing decision.
	always_comb begin
		nh_wide  = {1'b0, low_q} + quo_a - RW'(1);
		nl       = low_q + quo_b[CODE_BITS-1:0];
		rn_lo    = high_q < CODE_HALF;
		rn_hi    = !rn_lo && (low_q >= CODE_HALF);
		rn_mid   = !rn_lo && !rn_hi && (low_q >= CODE_QTR) && (high_q < CODE_3QTR);
		rn_emit  = rn_lo || rn_hi;
		if (rn_hi) begin
			rn_sub = CODE_HALF;
		end else if (rn_mid) begin
			rn_sub = CODE_QTR;
		end else begin
			rn_sub = '0;
		end
		low_sub   = low_q - rn_sub;
		high_sub  = high_q - rn_sub;
		pend_full = &pend_q;
		pend_inc  = pend_full ? pend_q : pend_q + FOLLOW_BITS'(1);
		out_free  = !out_valid_q || !code_stall;
		push      = (cmd.rn_step && rn_emit && hold_valid_q) || cmd.flush || cmd.finish;
	end

	// Interval and follow counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '1;
			pend_q <= '0;
			povf_q <= 1'b0;
		end else if (cmd.narrow) begin
			low_q  <= nl;
			high_q <= nh_wide[CODE_BITS-1:0];
		end else if (cmd.rn_step) begin
			low_q  <= {low_sub[CODE_BITS-2:0], 1'b0};
			high_q <= {high_sub[CODE_BITS-2:0], 1'b1};
			if (rn_emit) begin
				pend_q <= '0;
				povf_q <= 1'b0;
			end else if (rn_mid) begin
				pend_q <= pend_inc;
				povf_q <= povf_q | pend_full;
			end
		end else if (cmd.finish) begin
			low_q  <= '0;
			high_q <= '1;
			pend_q <= '0;
			povf_q <= 1'b0;
		end
	end

	// Hold register: a result waits here until it is known whether another follows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (cmd.rn_step && rn_emit) begin
			hold_valid_q <= 1'b1;
		end else if (cmd.flush) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rn_step && rn_emit) begin
			hold_bit_q    <= rn_hi;
			hold_follow_q <= pend_q;
			hold_sat_q    <= povf_q;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!code_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_bit_q    <= low_q >= CODE_QTR;
			out_follow_q <= pend_inc;
			out_sat_q    <= povf_q | pend_full;
			out_last_q   <= 1'b1;
		end else if (push) begin
			out_bit_q    <= hold_bit_q;
			out_follow_q <= hold_follow_q;
			out_sat_q    <= hold_sat_q;
			out_last_q   <= cmd.flush;
		end
	end

	// Status to the controller.
	always_comb begin
		sts.command    = cmd_q;
		sts.invalid    = (tot_q == '0) || (up_q > tot_q) || (lo_q >= up_q);
		sts.div_last   = cnt_q == CNT_W'(CODE_BITS);
		sts.empty      = quo_a <= quo_b;
		sts.rn_done    = !rn_emit && !rn_mid;
		sts.rn_emit    = rn_emit;
		sts.hold_valid = hold_valid_q;
		sts.out_free   = out_free;
	end

	assign code_valid       = out_valid_q;
	assign lead_bit         = out_bit_q;
	assign follow_count     = out_follow_q;
	assign follow_saturated = out_sat_q;
	assign last             = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ae_ctrl.sv =====
// Controller state machine of the arithmetic encoder.
`default_nettype none

module ae_ctrl import ae_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    symbol_valid,
	output logic         symbol_stall,
	input  wire ae_sts_t sts,
	output ae_cmd_t      cmd
);

	ae_state_t state_q;
	ae_state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (symbol_valid) state_next = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.command) begin
					state_next = ST_FINISH;
				end else if (sts.invalid) begin
					state_next = ST_IDLE;
				end else begin
					state_next = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_last) state_next = ST_NARROW;
			end
			ST_NARROW: begin
				state_next = sts.empty ? ST_IDLE : ST_RENORM;
			end
			ST_RENORM: begin
				if (sts.rn_done && (!sts.hold_valid || sts.out_free)) state_next = ST_IDLE;
			end
			ST_FINISH: begin
				if (sts.out_free) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd          = '0;
		symbol_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				symbol_stall = 1'b0;
				cmd.load     = symbol_valid;
			end
			ST_CHECK: begin
				cmd.div_start = !sts.command && !sts.invalid;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_NARROW: begin
				cmd.narrow = !sts.empty;
			end
			ST_RENORM: begin
				if (sts.rn_done) begin
					cmd.flush = sts.hold_valid && sts.out_free;
				end else begin
					cmd.rn_step = !sts.rn_emit || !sts.hold_valid || sts.out_free;
				end
			end
			ST_FINISH: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/arithmetic_encoder_core.sv =====
// Top level of the arithmetic encoder core.
`default_nettype none

// Integer arithmetic encoder of the classic interval scheme. Each symbol transaction
// carries the symbol's upper and lower cumulative counts and the model total; a finish
// transaction flushes the last code bit and reinitializes the interval for a new message.
// Every code bit leaves as one output transaction that carries the lead bit, the count of
// inverted follow bits that come after it, a saturation flag, and last on the final
// result of its input. The block works on one input at a time. An encode passes from
// acceptance through the check, the bit-serial division, the narrowing and any
// renormalizing shifts back to the next acceptance, and the output side may stall it;
// the two bit-serial dividers yield one quotient bit each cycle. A finish also passes
// through the check, and invalid counts are dropped there. The output register lets the next input be accepted
// while the last result still waits to be taken.
module arithmetic_encoder_core import ae_pkg::*; #(
	parameter int CODE_BITS   = 16,
	parameter int FREQ_BITS   = 14,
	parameter int FOLLOW_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   symbol_valid,
	output logic                        symbol_stall,
	input  wire logic                   command,
	input  wire logic [FREQ_BITS-1:0]   cum_upper,
	input  wire logic [FREQ_BITS-1:0]   cum_lower,
	input  wire logic [FREQ_BITS-1:0]   total,
	output logic                        code_valid,
	input  wire logic                   code_stall,
	output logic                        lead_bit,
	output logic [FOLLOW_BITS-1:0]      follow_count,
	output logic                        follow_saturated,
	output logic                        last
);

	ae_cmd_t cmd;
	ae_sts_t sts;

	// Sequencing of each transaction.
	ae_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.symbol_valid (symbol_valid),
		.symbol_stall (symbol_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// Interval arithmetic and result registers.
	ae_dp #(
		.CODE_BITS   (CODE_BITS),
		.FREQ_BITS   (FREQ_BITS),
		.FOLLOW_BITS (FOLLOW_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.command          (command),
		.cum_upper        (cum_upper),
		.cum_lower        (cum_lower),
		.total            (total),
		.code_valid       (code_valid),
		.code_stall       (code_stall),
		.lead_bit         (lead_bit),
		.follow_count     (follow_count),
		.follow_saturated (follow_saturated),
		.last             (last)
	);

endmodule

`default_nettype wire
